>>> hw/rtl/dnfp_pkg.sv
// Shared constants, types and helpers for the dense network forward pass block.
`timescale 1ns / 1ps
package dnfp_pkg;

  localparam int MaxNodes  = 16;
  localparam int MaxLayers = 8;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int LayerW    = $clog2(MaxLayers);
  localparam int WAddrW    = LayerW + 2 * NodeW;
  localparam int AAddrW    = NodeW + 1;
  localparam int AccW      = 48;

  // configuration register indexes
  localparam logic [2:0] RegLayerCount  = 3'd0;
  localparam logic [2:0] RegInputNodes  = 3'd1;
  localparam logic [2:0] RegHiddenNodes = 3'd2;
  localparam logic [2:0] RegOutputNodes = 3'd3;
  localparam logic [2:0] RegNodeBias    = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic               clr_acc;   // start a new node sum
    logic               rd_en;     // read weight and activation
    logic [WAddrW-1:0]  w_addr;
    logic [AAddrW-1:0]  a_addr;
    logic               mac_en;    // multiply the read pair (rd_en registered)
    logic               acc_en;    // add the product (mac_en registered)
    logic               fin_en;    // round, saturate and store the node
    logic [AAddrW-1:0]  dst_addr;
    logic               emit;      // load the output register
    logic [NodeW-1:0]   emit_node;
    logic               emit_last;
  } dnfp_cmd_t;

  // clamp a node count into 1..MaxNodes, returned as count minus one
  function automatic logic [NodeW-1:0] clamp_nodes_m1(input logic [4:0] n);
    logic [NodeW-1:0] r;
    if (n == 5'd0) r = '0;
    else if (n > 5'(MaxNodes)) r = NodeW'(MaxNodes - 1);
    else r = NodeW'(n - 5'd1);
    return r;
  endfunction

endpackage

>>> hw/rtl/dnfp_datapath.sv
// Datapath: weight and activation memories, multiply-accumulate, rounding.
`timescale 1ns / 1ps
module dnfp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_w_i,
  input  logic [dnfp_pkg::WAddrW-1:0]    wr_w_addr_i,
  input  logic                           wr_a_i,
  input  logic [dnfp_pkg::NodeW-1:0]     wr_a_addr_i,
  input  logic signed [15:0]             wr_data_i,
  input  logic signed [15:0]             bias_i,
  input  dnfp_pkg::dnfp_cmd_t            cmd_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [3:0]                     out_node_o,
  output logic signed [15:0]             out_value_o,
  output logic                           out_last_o
);

  logic signed [15:0] wmem [2**dnfp_pkg::WAddrW];
  logic signed [15:0] amem [2**dnfp_pkg::AAddrW];
  logic signed [15:0] w_q, a_q, fin_val;
  logic signed [31:0] prod_q;
  logic signed [dnfp_pkg::AccW-1:0] acc_q, sum;
  logic out_valid_q;
  logic [3:0] out_node_q;
  logic signed [15:0] out_value_q;
  logic out_last_q;

  // weight memory
  always_ff @(posedge clk_i) begin
    if (wr_w_i) wmem[wr_w_addr_i] <= wr_data_i;
    if (cmd_i.rd_en) w_q <= wmem[cmd_i.w_addr];
  end

  // activation memory: one write port shared by samples and node results
  always_ff @(posedge clk_i) begin
    if (wr_a_i) amem[{1'b0, wr_a_addr_i}] <= wr_data_i;
    else if (cmd_i.fin_en) amem[cmd_i.dst_addr] <= fin_val;
    if (cmd_i.rd_en) a_q <= amem[cmd_i.a_addr];
  end

  // multiply, then accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) prod_q <= w_q * a_q;
    if (cmd_i.clr_acc) acc_q <= '0;
    else if (cmd_i.acc_en) acc_q <= acc_q + dnfp_pkg::AccW'(prod_q);
  end

  // bias, round half up, floor divide by 2^14, saturate
  always_comb begin
    sum = acc_q + (dnfp_pkg::AccW'(bias_i) <<< 14) + dnfp_pkg::AccW'(8192);
    sum = sum >>> 14;
    if (sum > 32767) fin_val = 16'sh7fff;
    else if (sum < -32768) fin_val = -16'sh8000;
    else fin_val = sum[15:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_node_q  <= cmd_i.emit_node;
      out_value_q <= amem[cmd_i.a_addr];
      out_last_q  <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_node_o  = out_node_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

>>> hw/rtl/dnfp_ctrl.sv
// Controller: sequences layers, nodes and sources of a forward pass.
`timescale 1ns / 1ps
module dnfp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [3:0]                 layer_count_i,
  input  logic [4:0]                 input_nodes_i,
  input  logic [4:0]                 hidden_nodes_i,
  input  logic [4:0]                 output_nodes_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  output logic                       busy_o,
  output dnfp_pkg::dnfp_cmd_t        cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  localparam int NW = dnfp_pkg::NodeW;

  logic [2:0] state_q, state_d;
  logic [dnfp_pkg::LayerW-1:0] layer_q, layer_d, last_layer;
  logic [NW-1:0] node_q, node_d, src_q, src_d, prev_m1_q, prev_m1_d, cur_m1;
  logic [1:0] drain_q, drain_d;
  logic src_hi_q, src_hi_d;
  logic [3:0] lc;
  logic rd_q, mac_q;
  logic emit_ok;

  // clamp layer count to 2..MaxLayers
  always_comb begin
    lc = layer_count_i;
    if (lc < 4'd2) lc = 4'd2;
    if (lc > 4'(dnfp_pkg::MaxLayers)) lc = 4'(dnfp_pkg::MaxLayers);
    last_layer = dnfp_pkg::LayerW'(lc - 4'd1);
  end

  always_comb begin
    if (layer_q == '0) cur_m1 = dnfp_pkg::clamp_nodes_m1(input_nodes_i);
    else if (layer_q == last_layer) cur_m1 = dnfp_pkg::clamp_nodes_m1(output_nodes_i);
    else cur_m1 = dnfp_pkg::clamp_nodes_m1(hidden_nodes_i);
  end

  assign emit_ok = !out_valid_i || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d = state_q; layer_d = layer_q; node_d = node_q; src_d = src_q;
    prev_m1_d = prev_m1_q; drain_d = drain_q; src_hi_d = src_hi_q;
    cmd_o = '0;
    cmd_o.mac_en = rd_q;
    cmd_o.acc_en = mac_q;
    cmd_o.w_addr = {layer_q, node_q, src_q};
    cmd_o.a_addr = (layer_q == '0) ? {1'b0, node_q} : {src_hi_q, src_q};
    cmd_o.dst_addr = (layer_q == '0) ? {1'b0, node_q} : {~src_hi_q, node_q};
    cmd_o.emit_node = node_q;
    cmd_o.emit_last = (node_q == prev_m1_q);
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          layer_d = '0; node_d = '0; src_d = '0; src_hi_d = 1'b0;
          cmd_o.clr_acc = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        if (layer_q == '0 || src_q == prev_m1_q) begin
          drain_d = 2'd2;
          state_d = StDrain;
        end else begin
          src_d = src_q + 1'b1;
        end
      end
      StDrain: begin
        if (drain_q == 2'd0) state_d = StFin;
        else drain_d = drain_q - 2'd1;
      end
      StFin: begin
        cmd_o.fin_en = 1'b1;
        cmd_o.clr_acc = 1'b1;
        src_d = '0;
        if (node_q != cur_m1) begin
          node_d = node_q + 1'b1;
          state_d = StRead;
        end else begin
          node_d = '0;
          prev_m1_d = cur_m1;
          if (layer_q != '0) src_hi_d = ~src_hi_q;
          if (layer_q == last_layer) begin
            state_d = StEmit;
          end else begin
            layer_d = layer_q + 1'b1;
            state_d = StRead;
          end
        end
      end
      StEmit: begin
        cmd_o.a_addr = {src_hi_q, node_q};
        if (emit_ok) begin
          cmd_o.emit = 1'b1;
          if (node_q == prev_m1_q) state_d = StIdle;
          else node_d = node_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; layer_q <= '0; node_q <= '0; src_q <= '0;
      prev_m1_q <= '0; drain_q <= '0; src_hi_q <= 1'b0;
      rd_q <= 1'b0; mac_q <= 1'b0;
    end else begin
      state_q <= state_d; layer_q <= layer_d; node_q <= node_d; src_q <= src_d;
      prev_m1_q <= prev_m1_d; drain_q <= drain_d; src_hi_q <= src_hi_d;
      rd_q <= cmd_o.rd_en; mac_q <= rd_q;
    end
  end

  assign busy_o = (state_q != StIdle);

  // a node is finished only after its products have drained
  a_fin_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin_en |-> !rd_q && !mac_q) else $error("finish with MAC in flight");
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && node_q == prev_m1_q && cmd_o.emit) |=> state_q == StIdle)
    else $error("pass did not end after last beat");
  a_no_fin_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.fin_en && cmd_o.emit)) else $error("finish and emit together");

endmodule

>>> hw/rtl/dense_network_forward_pass.sv
// Top level: dense network forward pass with configuration registers.
`timescale 1ns / 1ps
// Linear fully connected network in fixed point (Q8.8 data, Q2.14 weights).
// Weight and sample beats are taken one a cycle while idle. A sample beat
// with last_sample starts a pass through one shared multiply-accumulate
// unit: each node reads its sources in turn (input layer nodes fan-in 1),
// drains its products, then rounds and stores; results then leave one
// beat per cycle unless stalled; input is stalled until the last result
// beat has been taken.
module dense_network_forward_pass (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [2:0]         layer_index_i,
  input  logic [3:0]         node_index_i,
  input  logic [3:0]         source_index_i,
  input  logic signed [15:0] value_i,
  input  logic               last_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         out_node_o,
  output logic signed [15:0] out_value_o,
  output logic               out_last_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic [3:0] layer_count_q;
  logic [4:0] input_nodes_q, hidden_nodes_q, output_nodes_q;
  logic signed [15:0] node_bias_q;
  logic busy, in_acc, start;
  dnfp_pkg::dnfp_cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= 4'd3; input_nodes_q <= 5'd4; hidden_nodes_q <= 5'd4;
      output_nodes_q <= 5'd2; node_bias_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dnfp_pkg::RegLayerCount:  layer_count_q  <= cfg_data_i[3:0];
        dnfp_pkg::RegInputNodes:  input_nodes_q  <= cfg_data_i[4:0];
        dnfp_pkg::RegHiddenNodes: hidden_nodes_q <= cfg_data_i[4:0];
        dnfp_pkg::RegOutputNodes: output_nodes_q <= cfg_data_i[4:0];
        dnfp_pkg::RegNodeBias:    node_bias_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy || out_valid_o;
  assign in_acc = in_valid_i && !in_stall_o;
  assign start = in_acc && action_i && last_sample_i;

  dnfp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start),
    .layer_count_i(layer_count_q),
    .input_nodes_i(input_nodes_q),
    .hidden_nodes_i(hidden_nodes_q),
    .output_nodes_i(output_nodes_q),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .busy_o(busy),
    .cmd_o(cmd)
  );

  dnfp_datapath u_dp (
    .clk_i, .rst_ni,
    .wr_w_i(in_acc && !action_i),
    .wr_w_addr_i({layer_index_i, node_index_i, source_index_i}),
    .wr_a_i(in_acc && action_i),
    .wr_a_addr_i(node_index_i),
    .wr_data_i(value_i),
    .bias_i(node_bias_q),
    .cmd_i(cmd),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_node_o(out_node_o),
    .out_value_o(out_value_o),
    .out_last_o(out_last_o)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_acc) else $error("input accepted during pass");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy) else $error("pass did not start");
  a_out_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy)) else $error("result without pass");

endmodule

>>> tb/dnfp_checker.sv
// Checker: watches the sample and result channels, predicts each pass and compares.
`timescale 1ns / 1ps
module dnfp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               action_i,
  input  logic [2:0]         layer_index_i,
  input  logic [3:0]         node_index_i,
  input  logic [3:0]         source_index_i,
  input  logic signed [15:0] value_i,
  input  logic               last_sample_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [3:0]         out_node_i,
  input  logic signed [15:0] out_value_i,
  input  logic               out_last_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 passes_o
);

  typedef struct packed {
    logic [3:0]         node;
    logic signed [15:0] value;
    logic               last;
  } node_result_t;

  logic signed [15:0] weights [dnfp_pkg::MaxLayers][dnfp_pkg::MaxNodes][dnfp_pkg::MaxNodes];
  logic signed [15:0] acts [2*dnfp_pkg::MaxNodes];
  logic [3:0]  layer_cnt;
  logic [4:0]  n_in, n_hid, n_out;
  logic signed [15:0] bias;
  node_result_t results_q [$];

  assign pending_o = results_q.size();

  function automatic int fit_nodes(logic [4:0] n);
    if (n == 0) return 1;
    if (n > dnfp_pkg::MaxNodes) return dnfp_pkg::MaxNodes;
    return n;
  endfunction

  // add bias, round half up to Q8.8, saturate
  function automatic logic signed [15:0] finish(longint acc);
    longint v, q;
    v = acc + longint'(bias) * 16384 + 8192;
    q = v >>> 14;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  task automatic run_pass();
    int layers, cur, prev, src, dst;
    longint acc;
    layers = layer_cnt;
    if (layers < 2) layers = 2;
    if (layers > dnfp_pkg::MaxLayers) layers = dnfp_pkg::MaxLayers;
    cur = fit_nodes(n_in);
    for (int n = 0; n < cur; n++)
      acts[n] = finish(longint'(weights[0][n][0]) * longint'(acts[n]));
    src = 0;
    prev = cur;
    for (int l = 1; l < layers; l++) begin
      dst = (src == 0) ? dnfp_pkg::MaxNodes : 0;
      cur = (l == layers - 1) ? fit_nodes(n_out) : fit_nodes(n_hid);
      for (int n = 0; n < cur; n++) begin
        acc = 0;
        for (int s = 0; s < prev; s++)
          acc += longint'(weights[l][n][s]) * longint'(acts[src + s]);
        acts[dst + n] = finish(acc);
      end
      src = dst;
      prev = cur;
    end
    for (int n = 0; n < cur; n++)
      results_q.push_back('{node: 4'(n), value: acts[src + n], last: (n == cur - 1)});
  endtask

  initial begin
    fail_count_o = 0;
    passes_o = 0;
    layer_cnt = 3; n_in = 4; n_hid = 4; n_out = 2; bias = 0;
  end

  always @(posedge clk_i) begin
    node_result_t exp_r;
    if (rst_ni) begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          dnfp_pkg::RegLayerCount:  layer_cnt = cfg_data_i[3:0];
          dnfp_pkg::RegInputNodes:  n_in = cfg_data_i[4:0];
          dnfp_pkg::RegHiddenNodes: n_hid = cfg_data_i[4:0];
          dnfp_pkg::RegOutputNodes: n_out = cfg_data_i[4:0];
          dnfp_pkg::RegNodeBias:    bias = cfg_data_i;
          default: ;
        endcase
      end
      // result beat compare
      if (out_valid_i && !out_stall_i) begin
        if (results_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result node=%0d value=%0d last=%0b",
                     out_node_i, out_value_i, out_last_i);
        end else begin
          exp_r = results_q.pop_front();
          if (exp_r.node !== out_node_i || exp_r.value !== out_value_i ||
              exp_r.last !== out_last_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: exp node=%0d value=%0d last=%0b got %0d %0d %0b",
                       exp_r.node, exp_r.value, exp_r.last,
                       out_node_i, out_value_i, out_last_i);
          end
        end
      end
      // input beat
      if (in_valid_i && !in_stall_i) begin
        if (!action_i) begin
          weights[layer_index_i][node_index_i][source_index_i] = value_i;
        end else begin
          acts[node_index_i] = value_i;
          if (last_sample_i) begin
            run_pass();
            passes_o++;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench top: drives weights, samples and configuration, and reports the verdict.
`timescale 1ns / 1ps
module tb_top;

  logic clk_i = 0, rst_ni;
  logic in_valid_i = 0, action_i = 0, last_sample_i = 0;
  logic [2:0] layer_index_i = 0;
  logic [3:0] node_index_i = 0, source_index_i = 0;
  logic signed [15:0] value_i = 0;
  logic out_stall_i = 0, cfg_we_i = 0;
  logic [2:0] cfg_index_i = 0;
  logic [15:0] cfg_data_i = 0;
  logic in_stall_o, out_valid_o, out_last_o;
  logic [3:0] out_node_o;
  logic signed [15:0] out_value_o;
  int fail_count, pending, passes;
  int send_idle = 0, recv_idle = 0;
  int hold_cycles = 0;
  int cycle = 0;
  int cfg_li, cfg_in, cfg_hid, cfg_out;
  bit hold_req = 0;

  dense_network_forward_pass uut (.*);

  dnfp_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .layer_index_i,
    .node_index_i, .source_index_i, .value_i, .last_sample_i, .out_valid_i(out_valid_o),
    .out_stall_i, .out_node_i(out_node_o), .out_value_i(out_value_o),
    .out_last_i(out_last_o), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .passes_o(passes)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle++;
    if (cycle > 900000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cycles = 3000;
      hold_req = 0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // one input beat; payload held while stalled, valid left high for the next beat
  task automatic send(bit act, logic [2:0] li, logic [3:0] ni, logic [3:0] si,
                      logic [15:0] v, bit lst);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      action_i <= $urandom_range(1);
      value_i <= $urandom;
      @(negedge clk_i);
    end
    in_valid_i <= 1; action_i <= act; layer_index_i <= li; node_index_i <= ni;
    source_index_i <= si; value_i <= v; last_sample_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= d;
    @(negedge clk_i);
  endtask

  // end the input stream, wait for all results, then a quiet gap
  task automatic drain();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  function automatic int eff(int n);
    return n == 0 ? 1 : (n > 16 ? 16 : n);
  endfunction

  // fill every weight the shape reads, then the samples, last one starting the pass
  task automatic full_network(bit extreme);
    int layers, prev, cur;
    logic [15:0] w;
    layers = cfg_li < 2 ? 2 : (cfg_li > 8 ? 8 : cfg_li);
    prev = 1;
    for (int l = 0; l < layers; l++) begin
      cur = l == 0 ? eff(cfg_in) : (l == layers - 1 ? eff(cfg_out) : eff(cfg_hid));
      for (int n = 0; n < cur; n++)
        for (int s = 0; s < prev; s++) begin
          w = extreme ? ($urandom_range(1) ? 16'h7fff : 16'h8000) : $urandom_range(8191) - 4096;
          send(0, l, n, s, w, $urandom_range(1));
        end
      prev = cur;
    end
    for (int n = 0; n < eff(cfg_in); n++)
      send(1, 0, n, $urandom, extreme ? ($urandom_range(1) ? 16'h7fff : 16'h8000) : $urandom,
           n == eff(cfg_in) - 1);
  endtask

  task automatic configure(int li, int ni, int hi, int oi, logic [15:0] b);
    cfg_li = li; cfg_in = ni; cfg_hid = hi; cfg_out = oi;
    write_reg(dnfp_pkg::RegLayerCount, li);
    write_reg(dnfp_pkg::RegInputNodes, ni);
    write_reg(dnfp_pkg::RegHiddenNodes, hi);
    write_reg(dnfp_pkg::RegOutputNodes, oi);
    write_reg(dnfp_pkg::RegNodeBias, b);
    cfg_we_i <= 0;
  endtask

  initial begin
    #1 rst_ni = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: reset shape, extremes, clamped counts
    cfg_li = 3; cfg_in = 4; cfg_hid = 4; cfg_out = 2;
    full_network(0);
    drain();
    configure(2, 1, 1, 1, 16'h7fff);
    full_network(1);
    send(1, 0, 0, 0, 16'h8000, 1);   // stale-free rewrite of the only sample
    drain();
    configure(0, 0, 0, 0, 16'h8000);
    full_network(1);
    send(1, 0, 15, 15, 16'h1234, 1); // node index beyond shape: pass on stale outputs
    drain();

    // random phases under varying idling and shapes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 45; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 45; end
        default: begin send_idle = 29; recv_idle = 29; end
      endcase
      if (ph == 7) configure(15, 31, 0, 1, $urandom);
      else if (ph == 5) configure(8, 4, 1, 16, $urandom_range(511) - 256);
      else configure($urandom_range(2, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                     $urandom_range(1, 5), $urandom_range(511) - 256);
      if (ph == 2) hold_req = 1;
      full_network(0);
      // a few passes reusing weights with fresh samples
      for (int r = 0; r < 3; r++) begin
        for (int n = 0; n < eff(cfg_in); n++)
          send(1, $urandom, n, $urandom, $urandom, n == eff(cfg_in) - 1);
        if ($urandom_range(3) == 0)
          send(0, $urandom, $urandom, $urandom, $urandom, $urandom_range(1));
      end
      if (ph == 2) begin
        // keep offering while the receiver holds off
        for (int n = 0; n < 6; n++) send(1, 0, 0, 0, $urandom, 1);
      end
      drain();
    end

    drain();
    $display("Covered %0d passes over shapes from 2 layers x 1 node up to 8 layers,",
             passes);
    $display("16 inputs and 16 outputs, with extremes, clamped counts and stalls on both sides.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
